// File: rtl/pfps_pkg.sv
// Package for the path-following particle step block.
// Holds fixed-point constants, codes and saturating helper functions.
// No dependencies.
`timescale 1ns / 1ps
package pfps_pkg;

  // Q16.16 constants.
  localparam int unsigned Q_ONE = 65536;
  localparam logic signed [31:0] VY_FLOOR = -32'sd6554;
  localparam logic signed [31:0] VY_RESET = -32'sd131072;
  localparam logic signed [31:0] SPEED_X_RST = 32'sd52429;
  localparam logic signed [31:0] SPEED_Y_RST = -32'sd52429;

  // Register reset values.
  localparam logic [30:0] RADIUS_RST = 31'd1310720;
  localparam logic [30:0] MAX_SPEED_RST = 31'd91750;
  localparam logic [30:0] MAX_FORCE_RST = 31'd22938;
  localparam logic [30:0] HEIGHT_RST = 31'd31457280;

  // Default parameter values.
  localparam int MARGIN_PX_DEF = 3;
  localparam int LOOKAHEAD_DEF = 20;

  // Configuration register indexes.
  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_END_X = 3'd2;
  localparam logic [2:0] REG_END_Y = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;
  localparam logic [2:0] REG_MAX_SPEED = 3'd5;
  localparam logic [2:0] REG_MAX_FORCE = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  // Step modes.
  localparam logic [1:0] MODE_FOLLOW = 2'd0;
  localparam logic [1:0] MODE_FORCE = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;
  localparam logic [1:0] MODE_PLACE = 2'd3;

  // Kinds of call to the scaling routine.
  localparam logic [1:0] KIND_SCALE = 2'd0;
  localparam logic [1:0] KIND_LIMIT = 2'd1;
  localparam logic [1:0] KIND_CMP = 2'd2;

  // Packed widths of the result item.
  localparam int OUT_TDATA_W = 136;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Saturate a 51-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat51(input logic signed [50:0] v);
    if (v[50:31] != {20{v[50]}}) begin
      return v[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat33({a[31], a} - {b[31], b});
  endfunction

  // Fixed-point product: divide by 2^16, truncating toward zero.
  function automatic logic signed [49:0] qmul(input logic signed [65:0] p);
    logic [65:0] pa;
    logic [65:0] s;
    logic [65:0] r;
    pa = p[65] ? -p : p;
    s = pa >> 16;
    r = p[65] ? -s : s;
    return r[49:0];
  endfunction

  // Magnitude of a 32-bit signed value as a 33-bit signed operand.
  function automatic logic signed [32:0] mag33(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = {v[31], v};
    return v[31] ? -e : e;
  endfunction

endpackage

// File: rtl/path_following_particle_step_top.sv
// Path-following particle step: top level with the step sequencer and the
// shared multiply, square-root and divide unit.
// Depends on pfps_pkg.
`timescale 1ns / 1ps
// Usage:
// The slave stream takes one request per step: tuser carries the mode
// (0 follow path, 1 add force, 2 advance and wrap, 3 place), tdata the
// x and y operands. Each request yields exactly one result on the master
// stream: location, velocity and the steered and wrapped flags after the step.
// The configuration port writes the path, radius and limit registers; the
// user must write them only while the block is idle, as the block does not
// enforce it. A write takes effect at the same clock edge.
// Modes 1 and 3 pass from the idle state through the finishing state to the
// output register. Modes 2 and 0 call the shared unit, whose square root and
// division each produce one result bit per cycle: once per advance step and
// up to six times per follow step. One request is in work at a time; tready
// is high only while the sequencer is idle.
// A finished result waits in the output register; while the receiver stalls,
// the next request is still accepted and its result waits in the sequencer.
// Reset puts the particle at the origin with velocity (0.8, -0.8) and no
// force, and loads the register defaults.
module path_following_particle_step_top
  import pfps_pkg::*;
#(
  parameter int MARGIN_PX = MARGIN_PX_DEF,
  parameter int LOOKAHEAD = LOOKAHEAD_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [63:0]            s_axis_tdata,  // x_operand[31:0], y_operand[63:32]
  input  logic [1:0]             s_axis_tuser,  // mode[1:0]
  // Result stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // loc_x[31:0], loc_y[63:32], vel_x[95:64], vel_y[127:96],
  // steered[128], wrapped[129], zero fill [135:130]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration port.
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i
);

  localparam logic signed [32:0] MARGIN = 33'(MARGIN_PX * Q_ONE);
  localparam logic [31:0] LOOK_N = 32'(LOOKAHEAD * Q_ONE);

  // Sequencer state codes.
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_FIN = 5'd1;
  localparam logic [4:0] SC_SQX = 5'd2;
  localparam logic [4:0] SC_SQY = 5'd3;
  localparam logic [4:0] SC_SUM = 5'd4;
  localparam logic [4:0] SC_LIM = 5'd5;
  localparam logic [4:0] SC_ROOT = 5'd6;
  localparam logic [4:0] SC_LEN = 5'd7;
  localparam logic [4:0] SC_MUL = 5'd8;
  localparam logic [4:0] SC_DVI = 5'd9;
  localparam logic [4:0] SC_DIV = 5'd10;
  localparam logic [4:0] SC_QST = 5'd11;
  localparam logic [4:0] ST_F1 = 5'd12;
  localparam logic [4:0] ST_F2 = 5'd13;
  localparam logic [4:0] ST_F3 = 5'd14;
  localparam logic [4:0] ST_F4 = 5'd15;
  localparam logic [4:0] ST_F5 = 5'd16;
  localparam logic [4:0] ST_F6 = 5'd17;
  localparam logic [4:0] ST_F7 = 5'd18;
  localparam logic [4:0] ST_F8 = 5'd19;
  localparam logic [4:0] ST_F9 = 5'd20;
  localparam logic [4:0] ST_F10 = 5'd21;
  localparam logic [4:0] ST_F11 = 5'd22;
  localparam logic [4:0] ST_F12 = 5'd23;
  localparam logic [4:0] ST_A1 = 5'd24;

  // Configuration registers.
  logic signed [31:0] sx_q, sy_q, ex_q, ey_q;
  logic [30:0] radius_q, max_speed_q, max_force_q, height_q;

  // Particle state.
  logic signed [31:0] pos_x_q, pos_y_q, spd_x_q, spd_y_q, acc_x_q, acc_y_q;

  // Sequencer and scaling routine registers.
  logic [4:0] state_q, ret_q;
  logic [1:0] kind_q;
  logic signed [31:0] vx_q, vy_q, rx_q, ry_q;
  logic [31:0] m_q;
  logic over_q, phase_q;
  logic [63:0] sh_q;
  logic [35:0] rem_q;
  logic [31:0] acc_q, len_q;
  logic [4:0] cnt_q;
  logic signed [65:0] prod_q;

  // Follow-step temporaries.
  logic signed [31:0] px_q, py_q, ux_q, uy_q, apx_q, apy_q;
  logic signed [31:0] dot_q, projx_q, nx_q, ny_q, tx_q, ty_q, xo_q;
  logic signed [49:0] t_q;
  logic steered_q, wrapped_q;

  // Output register.
  logic m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // Shared multiplier operands.
  logic signed [32:0] mul_a, mul_b;

  // Combinational helpers.
  logic signed [31:0] xo_in, yo_in, vy_clamp;
  logic signed [31:0] pbx, pby, ax_sum, ay_sum;
  logic signed [49:0] qm_now;
  logic [35:0] root_rem, root_trial;
  logic [32:0] div_rem;
  logic signed [31:0] q_signed;
  logic signed [32:0] top_v, lny;
  logic signed [31:0] lnx, ly_sum;
  logic s_acc;

  assign xo_in = s_axis_tdata[31:0];
  assign yo_in = s_axis_tdata[63:32];
  assign vy_clamp = (spd_y_q > VY_FLOOR) ? VY_RESET : spd_y_q;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign qm_now = qmul(prod_q);

  // Path direction and velocity-plus-force sums.
  assign pbx = ssub(ex_q, sx_q);
  assign pby = ssub(ey_q, sy_q);
  assign ax_sum = sadd(spd_x_q, acc_x_q);
  assign ay_sum = sadd(spd_y_q, acc_y_q);

  // One digit step of the square root and of the divider.
  assign root_rem = {rem_q[33:0], sh_q[63:62]};
  assign root_trial = {2'b00, acc_q, 2'b01};
  assign div_rem = {rem_q[31:0], sh_q[63]};
  assign q_signed = (phase_q ? vy_q[31] : vx_q[31]) ? -acc_q : acc_q;

  // Advance: new location and wrap bounds.
  assign lnx = sadd(pos_x_q, rx_q);
  assign ly_sum = sadd(pos_y_q, ry_q);
  assign lny = {ly_sum[31], ly_sum};
  assign top_v = {2'b00, height_q} + MARGIN;

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      SC_SQX: begin
        mul_a = {vx_q[31], vx_q};
        mul_b = {vx_q[31], vx_q};
      end
      SC_SQY: begin
        mul_a = {vy_q[31], vy_q};
        mul_b = {vy_q[31], vy_q};
      end
      SC_SUM: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      SC_MUL: begin
        mul_a = phase_q ? mag33(vy_q) : mag33(vx_q);
        mul_b = {1'b0, m_q};
      end
      ST_F3: begin
        mul_a = {apx_q[31], apx_q};
        mul_b = {ux_q[31], ux_q};
      end
      ST_F4: begin
        mul_a = {apy_q[31], apy_q};
        mul_b = {uy_q[31], uy_q};
      end
      ST_F6: begin
        mul_a = {ux_q[31], ux_q};
        mul_b = {dot_q[31], dot_q};
      end
      ST_F7: begin
        mul_a = {uy_q[31], uy_q};
        mul_b = {dot_q[31], dot_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      ex_q <= '0;
      ey_q <= '0;
      radius_q <= RADIUS_RST;
      max_speed_q <= MAX_SPEED_RST;
      max_force_q <= MAX_FORCE_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_X:   sx_q <= cfg_data_i;
        REG_START_Y:   sy_q <= cfg_data_i;
        REG_END_X:     ex_q <= cfg_data_i;
        REG_END_Y:     ey_q <= cfg_data_i;
        REG_RADIUS:    radius_q <= cfg_data_i[30:0];
        REG_MAX_SPEED: max_speed_q <= cfg_data_i[30:0];
        REG_MAX_FORCE: max_force_q <= cfg_data_i[30:0];
        REG_HEIGHT:    height_q <= cfg_data_i[30:0];
        default:       sx_q <= sx_q;
      endcase
    end
  end

  // Multiplier output register.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Step sequencer, scaling routine and particle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q <= ST_IDLE;
      kind_q <= KIND_SCALE;
      pos_x_q <= '0;
      pos_y_q <= '0;
      spd_x_q <= SPEED_X_RST;
      spd_y_q <= SPEED_Y_RST;
      acc_x_q <= '0;
      acc_y_q <= '0;
      vx_q <= '0;
      vy_q <= '0;
      rx_q <= '0;
      ry_q <= '0;
      m_q <= '0;
      over_q <= 1'b0;
      phase_q <= 1'b0;
      sh_q <= '0;
      rem_q <= '0;
      acc_q <= '0;
      len_q <= '0;
      cnt_q <= '0;
      px_q <= '0;
      py_q <= '0;
      ux_q <= '0;
      uy_q <= '0;
      apx_q <= '0;
      apy_q <= '0;
      dot_q <= '0;
      projx_q <= '0;
      nx_q <= '0;
      ny_q <= '0;
      tx_q <= '0;
      ty_q <= '0;
      xo_q <= '0;
      t_q <= '0;
      steered_q <= 1'b0;
      wrapped_q <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q <= '0;
    end else begin
      // The finishing state reloads the output register itself.
      if (m_axis_tready && (state_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        // Take a request and start its mode.
        ST_IDLE: begin
          if (s_acc) begin
            steered_q <= 1'b0;
            wrapped_q <= 1'b0;
            xo_q <= xo_in;
            case (s_axis_tuser)
              MODE_FOLLOW: begin
                spd_y_q <= vy_clamp;
                vx_q <= spd_x_q;
                vy_q <= vy_clamp;
                m_q <= LOOK_N;
                kind_q <= KIND_SCALE;
                ret_q <= ST_F1;
                state_q <= SC_SQX;
              end
              MODE_FORCE: begin
                acc_x_q <= sadd(acc_x_q, xo_in);
                acc_y_q <= sadd(acc_y_q, yo_in);
                state_q <= ST_FIN;
              end
              MODE_ADVANCE: begin
                vx_q <= ax_sum;
                vy_q <= ay_sum;
                m_q <= {1'b0, max_speed_q};
                kind_q <= KIND_LIMIT;
                ret_q <= ST_A1;
                state_q <= SC_SQX;
              end
              MODE_PLACE: begin
                pos_x_q <= xo_in;
                pos_y_q <= yo_in;
                state_q <= ST_FIN;
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end

        // Hand the result to the output register once it is free.
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q <= {6'b0, wrapped_q, steered_q, spd_y_q, spd_x_q, pos_y_q, pos_x_q};
            state_q <= ST_IDLE;
          end
        end

        // Scaling routine: squared length of the operand vector.
        SC_SQX: state_q <= SC_SQY;
        SC_SQY: begin
          sh_q <= prod_q[63:0];
          state_q <= SC_SUM;
        end
        SC_SUM: begin
          sh_q <= sh_q + prod_q[63:0];
          rem_q <= '0;
          acc_q <= '0;
          cnt_q <= 5'd31;
          state_q <= (kind_q == KIND_SCALE) ? SC_ROOT : SC_LIM;
        end

        // Compare against the squared limit; keep the vector if within it.
        SC_LIM: begin
          if (sh_q <= prod_q[63:0]) begin
            rx_q <= vx_q;
            ry_q <= vy_q;
            over_q <= 1'b0;
            state_q <= ret_q;
          end else begin
            over_q <= 1'b1;
            state_q <= (kind_q == KIND_CMP) ? ret_q : SC_ROOT;
          end
        end

        // Square root, one result bit per cycle.
        SC_ROOT: begin
          if (root_rem >= root_trial) begin
            rem_q <= root_rem - root_trial;
            acc_q <= {acc_q[30:0], 1'b1};
          end else begin
            rem_q <= root_rem;
            acc_q <= {acc_q[30:0], 1'b0};
          end
          sh_q <= {sh_q[61:0], 2'b00};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= SC_LEN;
          end
        end

        // A zero vector scales to zero.
        SC_LEN: begin
          len_q <= acc_q;
          phase_q <= 1'b0;
          if (acc_q == '0) begin
            rx_q <= '0;
            ry_q <= '0;
            state_q <= ret_q;
          end else begin
            state_q <= SC_MUL;
          end
        end

        SC_MUL: state_q <= SC_DVI;
        SC_DVI: begin
          rem_q <= {4'b0, prod_q[63:32]};
          sh_q <= {prod_q[31:0], 32'b0};
          acc_q <= '0;
          cnt_q <= 5'd31;
          state_q <= SC_DIV;
        end

        // Restoring divide of |v|*m by the length, one quotient bit per cycle.
        SC_DIV: begin
          if (div_rem >= {1'b0, len_q}) begin
            rem_q <= {3'b0, div_rem - {1'b0, len_q}};
            acc_q <= {acc_q[30:0], 1'b1};
          end else begin
            rem_q <= {3'b0, div_rem};
            acc_q <= {acc_q[30:0], 1'b0};
          end
          sh_q <= {sh_q[62:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= SC_QST;
          end
        end

        // Restore the sign and move on to the next component.
        SC_QST: begin
          if (!phase_q) begin
            rx_q <= q_signed;
            phase_q <= 1'b1;
            state_q <= SC_MUL;
          end else begin
            ry_q <= q_signed;
            state_q <= ret_q;
          end
        end

        // Follow: predicted location, then the unit path direction.
        ST_F1: begin
          px_q <= sadd(pos_x_q, rx_q);
          py_q <= sadd(pos_y_q, ry_q);
          vx_q <= pbx;
          vy_q <= pby;
          m_q <= 32'(Q_ONE);
          kind_q <= KIND_SCALE;
          ret_q <= ST_F2;
          state_q <= SC_SQX;
        end
        ST_F2: begin
          ux_q <= rx_q;
          uy_q <= ry_q;
          apx_q <= ssub(px_q, sx_q);
          apy_q <= ssub(py_q, sy_q);
          state_q <= ST_F3;
        end

        // Dot product of the offset with the direction.
        ST_F3: state_q <= ST_F4;
        ST_F4: begin
          t_q <= qm_now;
          state_q <= ST_F5;
        end
        ST_F5: begin
          dot_q <= sat51({t_q[49], t_q} + {qm_now[49], qm_now});
          state_q <= ST_F6;
        end

        // Projection and normal point; then the lookahead along the path.
        ST_F6: state_q <= ST_F7;
        ST_F7: begin
          projx_q <= sat51({qm_now[49], qm_now});
          state_q <= ST_F8;
        end
        ST_F8: begin
          nx_q <= sadd(sx_q, projx_q);
          ny_q <= sadd(sy_q, sat51({qm_now[49], qm_now}));
          vx_q <= pbx;
          vy_q <= pby;
          m_q <= LOOK_N;
          kind_q <= KIND_SCALE;
          ret_q <= ST_F9;
          state_q <= SC_SQX;
        end

        // Target point; distance test against the radius.
        ST_F9: begin
          tx_q <= sadd(nx_q, rx_q);
          ty_q <= sadd(ny_q, ry_q);
          vx_q <= ssub(px_q, nx_q);
          vy_q <= ssub(py_q, ny_q);
          m_q <= {1'b0, radius_q};
          kind_q <= KIND_CMP;
          ret_q <= ST_F10;
          state_q <= SC_SQX;
        end

        // Off the path: desired velocity toward the target.
        ST_F10: begin
          if (!over_q) begin
            state_q <= ST_FIN;
          end else begin
            vx_q <= ssub(tx_q, pos_x_q);
            vy_q <= ssub(ty_q, pos_y_q);
            m_q <= {1'b0, max_speed_q};
            kind_q <= KIND_SCALE;
            ret_q <= ST_F11;
            state_q <= SC_SQX;
          end
        end

        // Steering force, limited to the maximum force.
        ST_F11: begin
          vx_q <= ssub(rx_q, spd_x_q);
          vy_q <= ssub(ry_q, spd_y_q);
          m_q <= {1'b0, max_force_q};
          kind_q <= KIND_LIMIT;
          ret_q <= ST_F12;
          state_q <= SC_SQX;
        end
        ST_F12: begin
          acc_x_q <= sadd(acc_x_q, rx_q);
          acc_y_q <= sadd(acc_y_q, ry_q);
          steered_q <= 1'b1;
          state_q <= ST_FIN;
        end

        // Advance: move, clear the force and wrap vertically.
        ST_A1: begin
          spd_x_q <= rx_q;
          spd_y_q <= ry_q;
          acc_x_q <= '0;
          acc_y_q <= '0;
          if (lny < -MARGIN) begin
            pos_x_q <= xo_q;
            pos_y_q <= sat33(top_v);
            wrapped_q <= 1'b1;
          end else if (lny > top_v) begin
            pos_x_q <= xo_q;
            pos_y_q <= sat33(-MARGIN);
            wrapped_q <= 1'b1;
          end else begin
            pos_x_q <= lnx;
            pos_y_q <= lny[31:0];
          end
          state_q <= ST_FIN;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;

endmodule

// File: rtl/pfps_chk.sv
// Port-level checker for the path-following particle step block.
// Bound to path_following_particle_step_top; depends on pfps_pkg.
`timescale 1ns / 1ps
module pfps_chk
  import pfps_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One request at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a step is in work");

  // A new result only appears after the block has been busy.
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a step");

  // A step either steers or wraps, never both; fill bits stay zero.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[128] && m_axis_tdata[129]) &&
                      (m_axis_tdata[135:130] == 6'b0))
    else $error("bad result flags");

endmodule

bind path_following_particle_step_top pfps_chk u_pfps_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
